>>> rtl/tct_pkg.sv
`default_nettype none

package tct_pkg;

  // Lexer sizing
  localparam int WORD_BUF_CHARS = 9;
  localparam int VALUE_BITS     = 64;
  localparam int TOKEN_VALUE_W  = 64;
  localparam int PROD_W         = VALUE_BITS + 4;
  localparam int LEN_W          = $clog2(WORD_BUF_CHARS + 1);
  localparam int IDX_W          = $clog2(WORD_BUF_CHARS);

  // Bundle queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Number range limits
  localparam logic [PROD_W-1:0] LIMIT_UNS = {4'b0000, {VALUE_BITS{1'b1}}};
  localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(1) << (VALUE_BITS - 1);

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Token kinds
  localparam logic [4:0] KIND_END       = 5'd0;
  localparam logic [4:0] KIND_UNS       = 5'd1;
  localparam logic [4:0] KIND_NEG       = 5'd2;
  localparam logic [4:0] KIND_PLUS      = 5'd3;
  localparam logic [4:0] KIND_MINUS     = 5'd4;
  localparam logic [4:0] KIND_SLASH     = 5'd5;
  localparam logic [4:0] KIND_COLON     = 5'd6;
  localparam logic [4:0] KIND_ELLIPSIS  = 5'd7;
  localparam logic [4:0] KIND_NOW       = 5'd8;
  localparam logic [4:0] KIND_ALLDAY    = 5'd9;
  localparam logic [4:0] KIND_H         = 5'd10;
  localparam logic [4:0] KIND_M         = 5'd11;
  localparam logic [4:0] KIND_TODAY     = 5'd12;
  localparam logic [4:0] KIND_TOMORROW  = 5'd13;
  localparam logic [4:0] KIND_YESTERDAY = 5'd14;
  localparam logic [4:0] KIND_DAY       = 5'd15;
  localparam logic [4:0] KIND_MONTH     = 5'd16;
  localparam logic [4:0] KIND_YEAR      = 5'd17;
  localparam logic [4:0] KIND_D         = 5'd18;
  localparam logic [4:0] KIND_MO        = 5'd19;
  localparam logic [4:0] KIND_Y         = 5'd20;
  localparam logic [4:0] KIND_W         = 5'd21;
  localparam logic [4:0] KIND_VIEW      = 5'd22;
  localparam logic [4:0] KIND_QUICK     = 5'd23;
  localparam logic [4:0] KIND_TASK      = 5'd24;
  localparam logic [4:0] KIND_INVALID   = 5'd25;

  // Sub codes
  localparam logic [1:0] SUB_NONE     = 2'd0;
  localparam logic [1:0] SUB_OVERFLOW = 2'd0;
  localparam logic [1:0] SUB_SYMBOL   = 2'd1;
  localparam logic [1:0] SUB_KEYWORD  = 2'd2;
  localparam logic [1:0] SUB_LIST     = 2'd0;
  localparam logic [1:0] SUB_GRID     = 2'd1;
  localparam logic [1:0] SUB_WEEK     = 2'd2;
  localparam logic [1:0] SUB_CURRENT  = 2'd0;
  localparam logic [1:0] SUB_NEXT     = 2'd1;
  localparam logic [1:0] SUB_PREV     = 2'd2;
  localparam logic [1:0] SUB_ILLEGAL  = 2'd3;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_MINUS,
    LM_UNS,
    LM_NEG,
    LM_WORD,
    LM_DOTS
  } lex_mode_e;

  typedef logic [WORD_BUF_CHARS-1:0][7:0] word_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [1:0] sub;
  } tok_t;

  // Up to three tokens from one byte; only slot 0 can carry a number
  typedef struct packed {
    logic [1:0]               count;
    tok_t [2:0]               tok;
    logic [TOKEN_VALUE_W-1:0] value;
  } bundle_t;

  typedef struct packed {
    logic hit;
    tok_t tok;
  } kw_res_t;

  // Keyword set
  localparam int KW_COUNT   = 21;
  localparam int KW_MAX_LEN = 9;

  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "now", "allday", "h", "m", "today", "tomorrow", "yesterday", "day", "month",
    "year", "d", "mo", "y", "w", "list", "grid", "week", "current", "next",
    "prev", "task"
  };
  localparam int KW_LEN [KW_COUNT] = '{
    3, 6, 1, 1, 5, 8, 9, 3, 5, 4, 1, 2, 1, 1, 4, 4, 4, 7, 4, 4, 4
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    KIND_NOW, KIND_ALLDAY, KIND_H, KIND_M, KIND_TODAY, KIND_TOMORROW,
    KIND_YESTERDAY, KIND_DAY, KIND_MONTH, KIND_YEAR, KIND_D, KIND_MO, KIND_Y,
    KIND_W, KIND_VIEW, KIND_VIEW, KIND_VIEW, KIND_QUICK, KIND_QUICK,
    KIND_QUICK, KIND_TASK
  };
  localparam logic [1:0] KW_SUB [KW_COUNT] = '{
    SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE,
    SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE, SUB_NONE,
    SUB_LIST, SUB_GRID, SUB_WEEK, SUB_CURRENT, SUB_NEXT, SUB_PREV, SUB_NONE
  };

  // Parallel compare of the buffered word against every keyword
  function automatic kw_res_t kw_lookup(input word_t chars, input logic [LEN_W-1:0] len);
    kw_res_t res;
    logic    same;
    int      k;
    int      i;
    res = '0;
    for (k = KW_COUNT - 1; k >= 0; k--) begin
      same = (LEN_W'(KW_LEN[k]) == len);
      for (i = 0; i < KW_MAX_LEN; i++) begin
        if (i < KW_LEN[k]) begin
          if (chars[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]) begin
            same = 1'b0;
          end
        end
      end
      if (same) begin
        res.hit      = 1'b1;
        res.tok.kind = KW_KIND[k];
        res.tok.sub  = KW_SUB[k];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/time_command_tokenizer_core.sv
`default_nettype none

// Byte-serial tokenizer for short time/date commands. One ASCII byte is taken
// per clock on the input channel while the internal queue has room; whitespace
// is dropped, digit runs become numbers (a minus sign directly before a digit
// makes a negative integer), letter runs are looked up in the fixed keyword set,
// three dots make an ellipsis and a zero byte flushes any pending token and then
// gives an end token. A byte causes zero to three tokens; the tokens of one byte
// leave one per clock while the output is not stalled, the final one flagged by
// last_of_run_o. Sustained rate is one byte per clock as long as bytes give at
// most one token on average and the output is not stalled; the output register
// drains one token per clock while out_ready_i is high, and a four-entry queue
// of per-byte token groups soaks up bursts. A token is written to the queue when
// the byte that completes it is taken, and then loaded into the output register.
// Input ready depends only on the queue being full, never on input valid.

module time_command_tokenizer_core import tct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         char_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              token_kind_o,
  output logic [TOKEN_VALUE_W-1:0] token_value_o,
  output logic [1:0]              token_sub_o,
  output logic                    last_of_run_o
);

  // front -> queue
  logic    push;
  bundle_t push_data;
  logic    q_full;

  // queue -> back
  logic    head_valid;
  bundle_t head;
  logic    pop;

  // Lexer: mode tracking, number accumulate, word buffer, keyword match
  tct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_in_i   (char_in_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Per-byte token groups
  tct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Serialiser: one token per clock into the output register while it is not stalled
  tct_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .token_sub_o   (token_sub_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

>>> rtl/tct_front.sv
`default_nettype none

module tct_front import tct_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] char_in_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       q_full_i,
  output logic            push_o,
  output bundle_t         push_data_o
);

  lex_mode_e               mode_q, mode_d;
  logic [VALUE_BITS-1:0]   accum_q, accum_d;
  logic                    ovf_q, ovf_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic                    long_q, long_d;
  logic [1:0]              dots_q, dots_d;
  word_t                   chars_q;

  logic                    accept;
  logic                    is_digit, is_alpha, is_space, is_dot;
  logic [3:0]              digit;
  logic [PROD_W-1:0]       prod, limit;
  logic                    step_ovf;
  logic                    absorb;
  logic                    chr_we;
  logic [IDX_W-1:0]        chr_idx;
  kw_res_t                 kw;

  logic [1:0]              fl_cnt;
  tok_t                    fl_tok;
  logic                    main_v;
  tok_t                    main_tok;
  logic [TOKEN_VALUE_W-1:0] value;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_digit = char_in_i inside {[8'h30:8'h39]};
  assign is_alpha = char_in_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_space = (char_in_i == CH_SPACE) || (char_in_i inside {[CH_TAB:CH_CR]});
  assign is_dot   = (char_in_i == CH_DOT);
  assign digit    = char_in_i[3:0];

  // acc*10 + d against the limit; four spare bits hold it for any accumulator
  assign prod     = ({4'b0000, accum_q} << 3) + ({4'b0000, accum_q} << 1) + PROD_W'(digit);
  assign limit    = (mode_q == LM_NEG) ? LIMIT_NEG : LIMIT_UNS;
  assign step_ovf = (prod > limit);

  assign kw = kw_lookup(chars_q, len_q);

  // byte extends the pending token (or completes an ellipsis)
  assign absorb = ((mode_q == LM_MINUS) && is_digit) ||
                  (((mode_q == LM_UNS) || (mode_q == LM_NEG)) && is_digit) ||
                  ((mode_q == LM_WORD) && is_alpha) ||
                  ((mode_q == LM_DOTS) && is_dot);

  // next state
  always_comb begin
    mode_d  = mode_q;
    accum_d = accum_q;
    ovf_d   = ovf_q;
    len_d   = len_q;
    long_d  = long_q;
    dots_d  = dots_q;
    chr_we  = 1'b0;
    chr_idx = len_q[IDX_W-1:0];
    if (accept) begin
      case (mode_q)
        LM_MINUS: begin
          if (is_digit) begin
            mode_d  = LM_NEG;
            accum_d = VALUE_BITS'(digit);
            ovf_d   = 1'b0;
          end
        end
        LM_UNS, LM_NEG: begin
          if (is_digit && !ovf_q) begin
            if (step_ovf) begin
              ovf_d = 1'b1;
            end else begin
              accum_d = prod[VALUE_BITS-1:0];
            end
          end
        end
        LM_WORD: begin
          if (is_alpha) begin
            if (len_q < LEN_W'(WORD_BUF_CHARS)) begin
              chr_we = 1'b1;
              len_d  = len_q + 1'b1;
            end else begin
              long_d = 1'b1;
            end
          end
        end
        LM_DOTS: begin
          if (is_dot) begin
            if (dots_q == 2'd2) begin
              dots_d = 2'd0;
              mode_d = LM_IDLE;
            end else begin
              dots_d = 2'd2;
            end
          end else begin
            dots_d = 2'd0;
          end
        end
        default: begin
        end
      endcase
      if (!absorb) begin
        mode_d = LM_IDLE;
        if (is_digit) begin
          mode_d  = LM_UNS;
          accum_d = VALUE_BITS'(digit);
          ovf_d   = 1'b0;
        end else if (char_in_i == CH_MINUS) begin
          mode_d = LM_MINUS;
        end else if (is_alpha) begin
          mode_d  = LM_WORD;
          chr_we  = 1'b1;
          chr_idx = '0;
          len_d   = LEN_W'(1);
          long_d  = 1'b0;
        end else if (is_dot) begin
          mode_d = LM_DOTS;
          dots_d = 2'd1;
        end
      end
    end
  end

  // tokens caused by the current byte
  always_comb begin
    fl_cnt   = 2'd0;
    fl_tok   = '0;
    value    = '0;
    main_v   = 1'b0;
    main_tok = '0;
    case (mode_q)
      LM_MINUS: begin
        if (!is_digit) begin
          fl_cnt      = 2'd1;
          fl_tok.kind = KIND_MINUS;
        end
      end
      LM_UNS, LM_NEG: begin
        if (!is_digit) begin
          fl_cnt = 2'd1;
          if (ovf_q) begin
            fl_tok.kind = KIND_INVALID;
            fl_tok.sub  = SUB_OVERFLOW;
          end else if (mode_q == LM_NEG) begin
            fl_tok.kind = KIND_NEG;
            value       = TOKEN_VALUE_W'(0) - TOKEN_VALUE_W'(accum_q);
          end else begin
            fl_tok.kind = KIND_UNS;
            value       = TOKEN_VALUE_W'(accum_q);
          end
        end
      end
      LM_WORD: begin
        if (!is_alpha) begin
          fl_cnt = 2'd1;
          if (kw.hit && !long_q) begin
            fl_tok = kw.tok;
          end else begin
            fl_tok.kind = KIND_INVALID;
            fl_tok.sub  = SUB_KEYWORD;
          end
        end
      end
      LM_DOTS: begin
        if (is_dot) begin
          if (dots_q == 2'd2) begin
            fl_cnt      = 2'd1;
            fl_tok.kind = KIND_ELLIPSIS;
          end
        end else begin
          fl_cnt      = dots_q;
          fl_tok.kind = KIND_INVALID;
          fl_tok.sub  = SUB_SYMBOL;
        end
      end
      default: begin
      end
    endcase
    if (!absorb) begin
      if (char_in_i == CH_NUL) begin
        main_v        = 1'b1;
        main_tok.kind = KIND_END;
      end else if (is_space || is_digit || is_alpha || is_dot ||
                   (char_in_i == CH_MINUS)) begin
        main_v = 1'b0;
      end else begin
        main_v = 1'b1;
        case (char_in_i)
          CH_PLUS:  main_tok.kind = KIND_PLUS;
          CH_SLASH: main_tok.kind = KIND_SLASH;
          CH_COLON: main_tok.kind = KIND_COLON;
          default: begin
            main_tok.kind = KIND_INVALID;
            main_tok.sub  = SUB_SYMBOL;
          end
        endcase
      end
    end
  end

  always_comb begin
    push_data_o.count  = fl_cnt + {1'b0, main_v};
    push_data_o.tok[0] = (fl_cnt != 2'd0) ? fl_tok : main_tok;
    push_data_o.tok[1] = (fl_cnt == 2'd2) ? fl_tok : main_tok;
    push_data_o.tok[2] = main_tok;
    push_data_o.value  = value;
  end

  assign push_o = accept && (push_data_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= LM_IDLE;
      accum_q <= '0;
      ovf_q   <= 1'b0;
      len_q   <= '0;
      long_q  <= 1'b0;
      dots_q  <= 2'd0;
    end else begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      long_q  <= long_d;
      dots_q  <= dots_d;
    end
  end

  // letter buffer: undefined until written, only entries below len_q are used
  always_ff @(posedge clk_i) begin
    if (chr_we) begin
      chars_q[chr_idx] <= char_in_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tct_queue.sv
`default_nettype none

module tct_queue import tct_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         head_valid_o,
  output bundle_t      head_o
);

  bundle_t           mem_q [QUEUE_DEPTH];
  logic [QA_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]   cnt_q;
  logic              do_pop;

  assign full_o       = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tct_back.sv
`default_nettype none

module tct_back import tct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire bundle_t            head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              token_kind_o,
  output logic [TOKEN_VALUE_W-1:0] token_value_o,
  output logic [1:0]              token_sub_o,
  output logic                    last_of_run_o
);

  logic [1:0]               slot_q, slot_d;
  logic                     valid_q, valid_d;
  logic [4:0]               kind_q;
  logic [1:0]               sub_q;
  logic [TOKEN_VALUE_W-1:0] value_q;
  logic                     last_q;
  logic                     load;
  logic                     is_last;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = (slot_q == (head_i.count - 2'd1));
  assign pop_o   = load && is_last;

  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      slot_d  = is_last ? 2'd0 : (slot_q + 2'd1);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= head_i.tok[slot_q].kind;
      sub_q   <= head_i.tok[slot_q].sub;
      value_q <= (slot_q == 2'd0) ? head_i.value : '0;
      last_q  <= is_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign token_kind_o  = kind_q;
  assign token_sub_o   = sub_q;
  assign token_value_o = value_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

>>> rtl/tct_checker.sv
`default_nettype none

module tct_checker import tct_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic [7:0]               char_in_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [4:0]               token_kind_o,
  input wire logic [TOKEN_VALUE_W-1:0] token_value_o,
  input wire logic [1:0]               token_sub_o,
  input wire logic                     last_of_run_o
);

  // stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_value_o) && $stable(token_sub_o) && $stable(last_of_run_o))
    else $error("output token changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= KIND_INVALID)
    else $error("token kind out of range");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != KIND_UNS) && (token_kind_o != KIND_NEG)
      |-> token_value_o == '0)
    else $error("non-number token carries a value");

  a_sub_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_sub_o != SUB_NONE) |->
      (token_kind_o == KIND_VIEW) || (token_kind_o == KIND_QUICK) ||
      (token_kind_o == KIND_INVALID))
    else $error("sub code on a token kind that has none");

  a_sub_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_sub_o != SUB_ILLEGAL)
    else $error("illegal sub code");

endmodule

bind time_command_tokenizer_core tct_checker u_tct_checker (.*);

`default_nettype wire
